/* sv/rprs_pkg.sv */
// Package: opcodes, status codes, controller states and cell control struct for the scheduler.
package rprs_pkg;
	localparam int OP_W = 3;
	localparam int PRIO_W = 6;
	localparam int TIME_W = 32;
	localparam int STAT_W = 2;
	localparam int LOAD_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_TICK = 3'd0, OP_CREATE = 3'd1, OP_DELETE = 3'd2,
		OP_SLEEP = 3'd3, OP_SUSPEND = 3'd4, OP_RESUME = 3'd5,
		OP_RSV6 = 3'd6, OP_RSV7 = 3'd7
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK = 2'd0, ST_TAKEN = 2'd1, ST_NO_TASK = 2'd2, ST_IDLE_DEL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE, S_SCAN, S_PICK, S_OUT
	} state_t;

	// Broadcast from the controller to every wake-time cell.
	typedef struct packed {
		logic             scan;     // compare wake time this cycle
		logic [TIME_W-1:0] now;     // tick value to compare against
	} cell_ctl_t;
endpackage

/* sv/rprs_if.sv */
// Valid/ready channel interfaces for scheduler operations and results.
interface rprs_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [5:0] task_prio;
	logic [31:0] sleep_ticks;
	logic       idle_counting;
	modport source (output valid, opcode, task_prio, sleep_ticks, idle_counting, input ready);
	modport sink (input valid, opcode, task_prio, sleep_ticks, idle_counting, output ready);
endinterface

interface rprs_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [5:0] next_prio;
	logic       none_ready;
	logic [6:0] cpu_load;
	modport source (output valid, status, next_prio, none_ready, cpu_load, input ready);
	modport sink (input valid, status, next_prio, none_ready, cpu_load, output ready);
endinterface

/* sv/rtos_priority_ready_scheduler.sv */
// Top level: bitmap priority task scheduler with a rotating wake-time ring.
//
//  channel | dir | payload
//  op      | in  | opcode, task_prio, sleep_ticks, idle_counting
//  res     | out | status, next_prio, none_ready, cpu_load
//
// Non-tick ops go from accept through S_PICK to the result in S_OUT. A tick rotates the ring of
// NUM_TASKS cells once in S_SCAN, one cell per cycle past the head compare, then goes on
// to S_PICK and S_OUT. The priority pick is registered in S_PICK.
// After the result beat the block returns to S_IDLE, where it takes the next op beat.
// Reset clears flags, counters and load but leaves task 0 existing and ready; wake times are unset until slept.
// One op in flight; a stalled result holds in its register, no new beat taken.
module rtos_priority_ready_scheduler #(
	parameter int NUM_TASKS    = 64,
	parameter int WINDOW_TICKS = 1000
) (
	input  logic        clk,
	input  logic        arst_n,
	rprs_in_if.sink     op,
	rprs_out_if.source  res
);
	import rprs_pkg::*;
	localparam int IW = $clog2(NUM_TASKS);
	localparam int CW = $clog2(NUM_TASKS + 1);
	localparam int WW = $clog2(WINDOW_TICKS + 1);
	localparam int PW = $clog2(WINDOW_TICKS);
	localparam int RW = $clog2(WINDOW_TICKS + 100);

	state_t state_q, state_d;
	logic [NUM_TASKS-1:0] exists_q, ready_q, susp_q;
	logic [NUM_TASKS-1:0] dly;
	logic [TIME_W-1:0]    tick_q;
	logic [WW-1:0]        idle_q;
	logic [LOAD_W-1:0]    iq_q;
	logic [RW-1:0]        ir_q;
	logic [PW-1:0]        phase_q;
	logic [LOAD_W-1:0]    load_q;
	logic [CW-1:0]        cnt_q;
	logic [STAT_W-1:0]    stat_q;
	logic [PRIO_W-1:0]    best_q;
	logic                 any_q;
	cell_ctl_t            ctl;

	logic valid_p, present;
	logic [IW-1:0] pi;
	assign valid_p = {26'b0, op.task_prio} < 32'(NUM_TASKS);
	assign pi = IW'(op.task_prio);
	assign present = valid_p && exists_q[pi];

	logic [TIME_W-1:0] val [NUM_TASKS];
	logic [NUM_TASKS-1:0] hit, load_w, set_d, clr_d;
	logic scan;
	assign scan = (state_q == S_SCAN);
	assign ctl.scan = scan;
	assign ctl.now = tick_q;

	// Ring: cell i takes from cell i+1, head wraps; after NUM_TASKS shifts home.
	// During a scan only the head compare may clear a delayed flag, as it leaves cell 0.
	for (genvar i = 0; i < NUM_TASKS; i++) begin : g_ring
		localparam int NX = (i + 1) % NUM_TASKS;
		rprs_cell u_cell (.clk, .ctl, .load(load_w[i]),
			.load_val(tick_q + op.sleep_ticks), .prev_val(val[NX]),
			.val(val[i]), .hit(hit[i]));
		rprs_flag_cell u_flag (.clk, .arst_n, .scan, .set(set_d[i]), .clr(clr_d[i]),
			.prev_dly(dly[NX]), .hit_clr((NX == 0) ? hit[0] : 1'b0), .dly(dly[i]));
	end

	// Task held in cell 0 during scan step k is (k mod N); wake when it matches.
	logic [IW-1:0] head;
	assign head = IW'(cnt_q);
	logic wake;
	assign wake = scan && dly[0] && hit[0];

	logic accept;
	assign op.ready = (state_q == S_IDLE);
	assign accept = op.valid && op.ready;

	always_comb begin
		load_w = '0; set_d = '0; clr_d = '0;
		if (accept) begin
			unique case (opcode_t'(op.opcode))
				OP_CREATE: if (valid_p && !present) clr_d[pi] = 1'b1;
				OP_DELETE: if (op.task_prio != '0 && present) clr_d[pi] = 1'b1;
				OP_SLEEP: if (present && op.sleep_ticks != '0) begin
					load_w[pi] = 1'b1; set_d[pi] = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_d = (opcode_t'(op.opcode) == OP_TICK) ? S_SCAN : S_PICK;
			S_SCAN: if (cnt_q == CW'(NUM_TASKS - 1)) state_d = S_PICK;
			S_PICK: state_d = S_OUT;
			S_OUT: if (res.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Idle count with a running quotient: idle * 100 = iq * WINDOW_TICKS + ir.
	logic [WW-1:0] idle_n;
	logic [LOAD_W-1:0] iq_n;
	logic [RW-1:0] ir_n, ir_sum;
	logic idle_inc, ir_wrap;
	assign idle_inc = op.idle_counting && idle_q < WW'(WINDOW_TICKS);
	assign ir_sum = ir_q + RW'(100);
	assign ir_wrap = ir_sum >= RW'(WINDOW_TICKS);
	always_comb begin
		idle_n = idle_q; iq_n = iq_q; ir_n = ir_q;
		if (idle_inc) begin
			idle_n = idle_q + 1'b1;
			if (ir_wrap) begin
				iq_n = iq_q + 1'b1;
				ir_n = ir_sum - RW'(WINDOW_TICKS);
			end else begin
				ir_n = ir_sum;
			end
		end
	end

	logic [IW-1:0] best_c;
	logic any_c;
	always_comb begin
		best_c = '0; any_c = 1'b0;
		for (int q = 0; q < NUM_TASKS; q++)
			if (ready_q[q]) begin best_c = IW'(q); any_c = 1'b1; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			exists_q <= NUM_TASKS'(1); ready_q <= NUM_TASKS'(1); susp_q <= '0;
			tick_q <= '0; idle_q <= '0; phase_q <= '0; load_q <= '0; cnt_q <= '0;
			iq_q <= '0; ir_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
				unique case (opcode_t'(op.opcode))
					OP_TICK: begin
						tick_q <= tick_q + 1'b1;
						// window closes on a multiple of WINDOW_TICKS, and at the wrap to zero
						if (phase_q == PW'(WINDOW_TICKS - 1) || tick_q == '1) begin
							phase_q <= '0;
							load_q <= LOAD_W'(100) - iq_n;
							idle_q <= '0; iq_q <= '0; ir_q <= '0;
						end else begin
							phase_q <= phase_q + 1'b1;
							idle_q <= idle_n; iq_q <= iq_n; ir_q <= ir_n;
						end
					end
					OP_CREATE: if (valid_p && !present) begin
						exists_q[pi] <= 1'b1; ready_q[pi] <= 1'b1; susp_q[pi] <= 1'b0;
					end
					OP_DELETE: if (op.task_prio != '0 && present) begin
						exists_q[pi] <= 1'b0; ready_q[pi] <= 1'b0; susp_q[pi] <= 1'b0;
					end
					OP_SLEEP: if (present && op.sleep_ticks != '0) ready_q[pi] <= 1'b0;
					OP_SUSPEND: if (present && !susp_q[pi]) begin
						susp_q[pi] <= 1'b1; ready_q[pi] <= 1'b0;
					end
					OP_RESUME: if (present && susp_q[pi]) begin
						susp_q[pi] <= 1'b0;
						if (!dly[pi]) ready_q[pi] <= 1'b1;
					end
					default: ;
				endcase
			end
			if (scan) begin
				cnt_q <= cnt_q + 1'b1;
				if (wake && !susp_q[head]) ready_q[head] <= 1'b1;
			end
		end
	end

	// wake clears the flag of cell 0 via hit_clr of the cell that takes from it (cell NUM_TASKS-1)
	always_ff @(posedge clk) begin
		if (accept) begin
			if (opcode_t'(op.opcode) == OP_CREATE)
				stat_q <= !valid_p ? ST_NO_TASK : present ? ST_TAKEN : ST_OK;
			else if (opcode_t'(op.opcode) == OP_DELETE)
				stat_q <= (op.task_prio == '0) ? ST_IDLE_DEL : !present ? ST_NO_TASK : ST_OK;
			else if (opcode_t'(op.opcode) == OP_SLEEP || opcode_t'(op.opcode) == OP_SUSPEND
				|| opcode_t'(op.opcode) == OP_RESUME)
				stat_q <= present ? ST_OK : ST_NO_TASK;
			else stat_q <= ST_OK;
		end
		if (state_q == S_PICK) begin
			best_q <= PRIO_W'(best_c); any_q <= any_c;
		end
	end

	assign res.valid = (state_q == S_OUT);
	assign res.status = stat_q;
	assign res.next_prio = any_q ? best_q : '0;
	assign res.none_ready = ~any_q;
	assign res.cpu_load = load_q;
endmodule

/* sv/rprs_cell.sv */
// One wake-time cell of the delay ring: holds an entry, rotates it, flags a match.
module rprs_cell (
	input  logic                 clk,
	input  rprs_pkg::cell_ctl_t  ctl,
	input  logic                 load,
	input  logic [31:0]          load_val,
	input  logic [31:0]          prev_val,
	output logic [31:0]          val,
	output logic                 hit
);
	import rprs_pkg::*;
	logic [TIME_W-1:0] val_q;
	// rotate one place per scan cycle; load takes the write from the controller
	always_ff @(posedge clk) begin
		if (load) val_q <= load_val;
		else if (ctl.scan) val_q <= prev_val;
	end
	assign val = val_q;
	assign hit = ctl.scan && (val_q == ctl.now);
endmodule

/* sv/rprs_flag_cell.sv */
// Per-task flag cell of the status ring: holds a delayed bit, rotates with the wake times.
module rprs_flag_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic scan,
	input  logic set,
	input  logic clr,
	input  logic prev_dly,
	input  logic hit_clr,
	output logic dly
);
	logic dly_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dly_q <= 1'b0;
		else if (set) dly_q <= 1'b1;
		else if (clr) dly_q <= 1'b0;
		else if (scan) dly_q <= prev_dly & ~hit_clr;
	end
	assign dly = dly_q;
endmodule

/* tb/sv/tb_rtos_priority_ready_scheduler.sv */
// Testbench for the priority ready scheduler: directed and random operations with a scheduler model.
`timescale 1ns / 1ps

import rprs_pkg::*;

typedef struct {
	status_t    status;
	logic [5:0] next_prio;
	logic       none_ready;
	logic [6:0] cpu_load;
} sched_result_t;

// Mirror of the scheduler state; queues the expected result of each op beat.
class sched_model;
	localparam int NTASK = 64;
	localparam int WINDOW = 1000;

	logic [63:0]   exists_m, ready_m, delayed_m, susp_m;
	logic [31:0]   wake_at [NTASK];
	logic [31:0]   ticks_now;
	int unsigned   idle_ticks;
	logic [6:0]    load_pct;
	sched_result_t pending_q[$];
	int            mismatches;
	int            ticks_seen, wakes_seen, loads_seen;

	function new();
		exists_m = 64'd1;
		ready_m = 64'd1;
		delayed_m = '0;
		susp_m = '0;
		ticks_now = '0;
		idle_ticks = 0;
		load_pct = '0;
		mismatches = 0;
		ticks_seen = 0;
		wakes_seen = 0;
		loads_seen = 0;
	endfunction

	function void note_op(opcode_t opc, logic [5:0] p, logic [31:0] nticks, logic idle);
		sched_result_t r;
		bit present;
		present = exists_m[p];
		r.status = ST_OK;
		case (opc)
			OP_TICK: begin
				ticks_seen++;
				ticks_now = ticks_now + 32'd1;
				if (idle && idle_ticks < WINDOW)
					idle_ticks++;
				if (ticks_now % WINDOW == 0) begin
					load_pct = 7'(100 - idle_ticks * 100 / WINDOW);
					idle_ticks = 0;
					loads_seen++;
				end
				for (int i = 0; i < NTASK; i++) begin
					if (delayed_m[i] && wake_at[i] == ticks_now) begin
						delayed_m[i] = 1'b0;
						wakes_seen++;
						if (!susp_m[i])
							ready_m[i] = 1'b1;
					end
				end
			end
			OP_CREATE: begin
				if (present) r.status = ST_TAKEN;
				else begin
					exists_m[p] = 1'b1;
					ready_m[p] = 1'b1;
					delayed_m[p] = 1'b0;
					susp_m[p] = 1'b0;
				end
			end
			OP_DELETE: begin
				if (p == 0) r.status = ST_IDLE_DEL;
				else if (!present) r.status = ST_NO_TASK;
				else begin
					// dropping the task also cancels any pending delay
					exists_m[p] = 1'b0;
					ready_m[p] = 1'b0;
					delayed_m[p] = 1'b0;
					susp_m[p] = 1'b0;
				end
			end
			OP_SLEEP: begin
				if (!present) r.status = ST_NO_TASK;
				else if (nticks != 0) begin
					wake_at[p] = ticks_now + nticks;
					delayed_m[p] = 1'b1;
					ready_m[p] = 1'b0;
				end
			end
			OP_SUSPEND: begin
				if (!present) r.status = ST_NO_TASK;
				else if (!susp_m[p]) begin
					susp_m[p] = 1'b1;
					ready_m[p] = 1'b0;
				end
			end
			OP_RESUME: begin
				if (!present) r.status = ST_NO_TASK;
				else if (susp_m[p]) begin
					susp_m[p] = 1'b0;
					if (!delayed_m[p])
						ready_m[p] = 1'b1;
				end
			end
			default: ;
		endcase
		r.next_prio = '0;
		r.none_ready = 1'b1;
		for (int q = NTASK - 1; q >= 0; q--) begin
			if (ready_m[q]) begin
				r.next_prio = 6'(q);
				r.none_ready = 1'b0;
				break;
			end
		end
		r.cpu_load = load_pct;
		pending_q.push_back(r);
	endfunction

	function void check_result(logic [1:0] st, logic [5:0] np, logic nr, logic [6:0] ld);
		sched_result_t e;
		if (pending_q.size() == 0) begin
			$display("%0t: unexpected result beat status=%0d next=%0d none=%0d load=%0d",
				$time, st, np, nr, ld);
			mismatches++;
			return;
		end
		e = pending_q.pop_front();
		if (st !== e.status) begin
			$display("%0t: status exp %0d got %0d", $time, e.status, st);
			mismatches++;
		end
		if (np !== e.next_prio) begin
			$display("%0t: next_prio exp %0d got %0d", $time, e.next_prio, np);
			mismatches++;
		end
		if (nr !== e.none_ready) begin
			$display("%0t: none_ready exp %0d got %0d", $time, e.none_ready, nr);
			mismatches++;
		end
		if (ld !== e.cpu_load) begin
			$display("%0t: cpu_load exp %0d got %0d", $time, e.cpu_load, ld);
			mismatches++;
		end
	endfunction
endclass

module tb_rtos_priority_ready_scheduler;
	localparam int N_RANDOM   = 1450;
	localparam int QUIET_FROM = 1300;   // last part of the run: no idling either side
	localparam int HOLD_CYC   = 400;    // long receiver hold-off
	localparam int DOG_LIMIT  = 6000;   // cycles with no beat before giving up

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rprs_in_if  op_if();
	rprs_out_if res_if();

	rtos_priority_ready_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_if),
		.res    (res_if)
	);

	sched_model model = new();
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int op_beats = 0;

	always #5 clk = ~clk;

	// Keep every input known from time zero.
	initial begin
		op_if.valid = 1'b0;
		op_if.opcode = '0;
		op_if.task_prio = '0;
		op_if.sleep_ticks = '0;
		op_if.idle_counting = 1'b0;
		res_if.ready = 1'b0;
	end

	// Send one op beat; optional random gap first. Returns after the accepting edge.
	task automatic send_op(opcode_t opc, logic [5:0] p, logic [31:0] nt, logic idle);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 19);
		if (gap != 0) begin
			op_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_if.valid <= 1'b1;
		op_if.opcode <= opc;
		op_if.task_prio <= p;
		op_if.sleep_ticks <= nt;
		op_if.idle_counting <= idle;
		@(posedge clk);
		while (!op_if.ready) @(posedge clk);
		model.note_op(opc, p, nt, idle);
		op_beats++;
	endtask

	task automatic wait_drained();
		while (model.pending_q.size() != 0) @(posedge clk);
	endtask

	// Result side: random stall bursts, one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				res_if.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// Pre-edge values are sampled here, so the check sees the beat that the edge takes.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			model.check_result(res_if.status, res_if.next_prio, res_if.none_ready,
				res_if.cpu_load);
	end

	// Watchdog: cycles with no beat on either channel.
	initial begin
		int still;
		still = 0;
		forever begin
			@(posedge clk);
			if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready))
				still = 0;
			else if (++still >= DOG_LIMIT) begin
				$display("%0t: watchdog, no beat for %0d cycles", $time, still);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int r;
		opcode_t opc;
		logic [5:0] p;
		logic [31:0] nt;
		int idle_bias;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every op and status, wake paths, reserved opcodes.
		send_op(OP_CREATE, 6'd63, '0, 1'b0);
		send_op(OP_CREATE, 6'd63, '0, 1'b0);           // already taken
		send_op(OP_DELETE, 6'd0, '0, 1'b0);            // idle cannot go
		send_op(OP_DELETE, 6'd5, '0, 1'b0);            // absent task
		send_op(OP_SLEEP, 6'd5, 32'd3, 1'b0);
		send_op(OP_SUSPEND, 6'd5, '0, 1'b0);
		send_op(OP_RESUME, 6'd5, '0, 1'b0);
		send_op(OP_SLEEP, 6'd63, 32'd0, 1'b0);         // zero ticks: no effect
		send_op(OP_SLEEP, 6'd63, 32'd2, 1'b1);
		send_op(OP_TICK, 6'd0, '1, 1'b1);
		send_op(OP_TICK, 6'd0, '0, 1'b0);              // 63 wakes
		send_op(OP_SUSPEND, 6'd63, '0, 1'b0);
		send_op(OP_SUSPEND, 6'd63, '0, 1'b0);          // already suspended
		send_op(OP_SLEEP, 6'd63, 32'd1, 1'b0);
		send_op(OP_TICK, 6'd0, '0, 1'b1);              // wakes while suspended
		send_op(OP_RESUME, 6'd63, '0, 1'b0);
		send_op(OP_RESUME, 6'd63, '0, 1'b0);           // not suspended
		send_op(OP_SUSPEND, 6'd0, '0, 1'b0);
		send_op(OP_DELETE, 6'd63, '0, 1'b0);           // nothing ready now
		send_op(OP_TICK, 6'd0, '0, 1'b0);
		send_op(OP_RESUME, 6'd0, '0, 1'b0);
		send_op(OP_CREATE, 6'd10, '0, 1'b0);
		send_op(OP_SLEEP, 6'd10, 32'hFFFF_FFFF, 1'b0);
		send_op(OP_DELETE, 6'd10, '0, 1'b0);           // cancels the delay
		send_op(OP_RSV6, 6'd33, 32'h5A5A_A5A5, 1'b1);
		send_op(OP_RSV7, 6'd63, '1, 1'b1);

		// Random: tick heavy so delays expire and load windows advance.
		idle_bias = 50;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 200 == 0)
				idle_bias = $urandom_range(0, 100);
			if (n == 400)
				hold_req = 1'b1;
			if (n == 800) begin
				op_if.valid <= 1'b0;
				@(posedge clk);
				wait_drained();
			end
			if (n == QUIET_FROM)
				quiet = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 68) opc = OP_TICK;
			else if (r < 77) opc = OP_CREATE;
			else if (r < 82) opc = OP_DELETE;
			else if (r < 91) opc = OP_SLEEP;
			else if (r < 95) opc = OP_SUSPEND;
			else if (r < 99) opc = OP_RESUME;
			else opc = ($urandom_range(0, 1) != 0) ? OP_RSV6 : OP_RSV7;
			// keep most ops on a small task set so they find existing tasks
			p = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 15)) : 6'($urandom);
			nt = ($urandom_range(0, 9) < 7) ? 32'($urandom_range(0, 12)) : $urandom;
			send_op(opc, p, nt, $urandom_range(1, 100) <= idle_bias);
		end
		op_if.valid <= 1'b0;

		wait_drained();
		repeat (80) @(posedge clk);
		$display("Ran %0d ops: %0d ticks, %0d wakeups, %0d load windows.",
			op_beats, model.ticks_seen, model.wakes_seen, model.loads_seen);
		$display("Covered all opcodes and status codes with random stalls and a long hold-off.");
		if (model.mismatches == 0 && model.pending_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

/* files.f */
sv/rprs_pkg.sv
sv/rprs_if.sv
sv/rprs_cell.sv
sv/rprs_flag_cell.sv
sv/rtos_priority_ready_scheduler.sv
tb/sv/tb_rtos_priority_ready_scheduler.sv
